>>> sv/rmv_pkg.sv
// Shared constants, codes and types of the running mean and variance core.
`timescale 1ns / 1ps
`default_nettype none

package rmv_pkg;

  // Fixed field widths of the result word.
  localparam int COUNT_W = 32;
  localparam int OUT_W   = 32;
  localparam int SUM_W   = 64;
  localparam int DEV_W   = 32;

  // Width of the shared compare and subtract unit and of its step counter.
  localparam int ITER_W = 36;
  localparam int CNT_W  = $clog2(SUM_W);

  // Operation codes of the input word.
  localparam logic FUNC_ADD   = 1'b0;
  localparam logic FUNC_CLEAR = 1'b1;

  typedef enum logic {
    MODE_DIV  = 1'b0,
    MODE_SQRT = 1'b1
  } iter_mode_e;

  typedef struct packed {
    iter_mode_e         mode;
    logic [ITER_W-1:0]  rem;
    logic [1:0]         in_bits;
    logic [COUNT_W-1:0] divisor;
    logic [DEV_W-1:0]   root;
  } iter_req_t;

  typedef struct packed {
    logic [ITER_W-1:0] rem;
    logic              bit_val;
  } iter_rsp_t;

endpackage

`default_nettype wire

>>> sv/rmv_if.sv
// Handshake channels of the running mean and variance core.
`timescale 1ns / 1ps
`default_nettype none

interface rmv_in_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic [31:0] sample;

  modport source (output valid, output func, output sample, input ready);
  modport sink (input valid, input func, input sample, output ready);
endinterface

interface rmv_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] sample_count;
  logic [31:0] mean_value;
  logic [63:0] squared_dev_sum;
  logic [31:0] std_deviation;
  logic        overflow;

  modport source (
    output valid, output sample_count, output mean_value, output squared_dev_sum,
    output std_deviation, output overflow, input ready
  );
  modport sink (
    input valid, input sample_count, input mean_value, input squared_dev_sum,
    input std_deviation, input overflow, output ready
  );
endinterface

`default_nettype wire

>>> sv/rmv_iter_unit.sv
// Shared compare and subtract step for restoring division and digit-by-digit square root.
`timescale 1ns / 1ps
`default_nettype none

module rmv_iter_unit (
  input  rmv_pkg::iter_req_t req_i,
  output rmv_pkg::iter_rsp_t rsp_o
);

  logic [rmv_pkg::ITER_W-1:0] opa;
  logic [rmv_pkg::ITER_W-1:0] opb;
  logic [rmv_pkg::ITER_W:0]   diff;

  always_comb begin
    case (req_i.mode)
      rmv_pkg::MODE_SQRT: begin
        // Bring down two radicand bits; trial value is 4 * root + 1.
        opa = {req_i.rem[rmv_pkg::ITER_W-3:0], req_i.in_bits};
        opb = {{(rmv_pkg::ITER_W - rmv_pkg::DEV_W - 2){1'b0}}, req_i.root, 2'b01};
      end
      rmv_pkg::MODE_DIV: begin
        opa = {req_i.rem[rmv_pkg::ITER_W-2:0], req_i.in_bits[1]};
        opb = {{(rmv_pkg::ITER_W - rmv_pkg::COUNT_W){1'b0}}, req_i.divisor};
      end
      default: begin
        opa = {req_i.rem[rmv_pkg::ITER_W-2:0], req_i.in_bits[1]};
        opb = {{(rmv_pkg::ITER_W - rmv_pkg::COUNT_W){1'b0}}, req_i.divisor};
      end
    endcase
    diff          = {1'b0, opa} - {1'b0, opb};
    rsp_o.bit_val = ~diff[rmv_pkg::ITER_W];
    rsp_o.rem     = diff[rmv_pkg::ITER_W] ? opa : diff[rmv_pkg::ITER_W-1:0];
  end

endmodule

`default_nettype wire

>>> sv/running_mean_variance_core.sv
// Top level of the running mean and variance core (Welford update, fixed point).
//
//   channel | direction | word contents
//   --------+-----------+-----------------------------------------------------------
//   in_i    | sink      | func (add sample / clear), sample (signed Q16.16)
//   res_o   | source    | sample_count, mean_value, squared_dev_sum, std_deviation,
//           |           | overflow
//
// An add word runs through the mean division, the mean update, the product, the sum update,
// the division of sum by count and the root; the first sample after a clear starts at the sum update.
// When the scaled variance cannot fit, the root steps are skipped and the word ends sooner.
// A clear word goes straight to the output state. Both divisions and the root use the one shared compare
// and subtract unit: SAMPLE_WIDTH steps for the mean division, 64 for sum over count, 32
// for the root.
// Reset clears the statistics and the sequencer at once; no clearing pass is needed.
// A result sits in an output register, so the core keeps working while it waits to be
// taken; it only stalls in its last state when a newer result is ready and the old one
// has still not been taken.
`timescale 1ns / 1ps
`default_nettype none

module running_mean_variance_core #(
  parameter int SAMPLE_WIDTH = 32,
  parameter int FRAC_BITS    = 16
) (
  input  wire              clk_i,
  input  wire              rst_ni,
  rmv_in_if.sink           in_i,
  rmv_out_if.source        res_o
);

  localparam int SW       = SAMPLE_WIDTH;
  localparam int SatShift = rmv_pkg::SUM_W - FRAC_BITS;

  // Sequencer states, one-hot.
  typedef enum logic [8:0] {
    S_IDLE   = 9'b0_0000_0001,
    S_DIVQ   = 9'b0_0000_0010,
    S_MEAN   = 9'b0_0000_0100,
    S_MUL    = 9'b0_0000_1000,
    S_SUM    = 9'b0_0001_0000,
    S_DIVV   = 9'b0_0010_0000,
    S_SQPREP = 9'b0_0100_0000,
    S_SQRT   = 9'b0_1000_0000,
    S_FINISH = 9'b1_0000_0000
  } state_e;

  state_e state_q, state_d;

  // Statistics kept between words.
  logic [rmv_pkg::COUNT_W-1:0] count_q, count_d;
  logic signed [SW-1:0]        mean_q, mean_d;
  logic [rmv_pkg::SUM_W-1:0]   sum_q, sum_d;
  logic                        ovf_q, ovf_d;

  // Working registers of the current word.
  logic [rmv_pkg::CNT_W-1:0]   cnt_q, cnt_d;
  logic [rmv_pkg::SUM_W-1:0]   work_q, work_d;
  logic [rmv_pkg::ITER_W-1:0]  rem_q, rem_d;
  logic [rmv_pkg::DEV_W-1:0]   root_q, root_d;
  logic [SW-1:0]               mag1_q, mag1_d;
  logic [SW-1:0]               mag2_q, mag2_d;
  logic                        neg_q, neg_d;
  logic [2*SW-1:0]             prod_q, prod_d;

  // Output register.
  logic                        out_valid_q, out_valid_d;
  logic [rmv_pkg::COUNT_W-1:0] out_count_q, out_count_d;
  logic [rmv_pkg::OUT_W-1:0]   out_mean_q, out_mean_d;
  logic [rmv_pkg::SUM_W-1:0]   out_sum_q, out_sum_d;
  logic [rmv_pkg::DEV_W-1:0]   out_dev_q, out_dev_d;
  logic                        out_ovf_q, out_ovf_d;

  // Combinational helpers.
  logic                        in_fire;
  logic signed [SW-1:0]        x;
  logic [SW:0]                 d1;
  logic [SW:0]                 d1_mag;
  logic [SW-1:0]               quot;
  logic [SW:0]                 mean_next;
  logic [2*SW-1:0]             prod_shift;
  logic [rmv_pkg::SUM_W:0]     sum_ext;
  logic signed [rmv_pkg::OUT_W-1:0] mean_wide;

  rmv_pkg::iter_req_t iter_req;
  rmv_pkg::iter_rsp_t iter_rsp;

  rmv_iter_unit u_iter (
    .req_i (iter_req),
    .rsp_o (iter_rsp)
  );

  assign in_i.ready = (state_q == S_IDLE);
  assign in_fire    = in_i.valid && in_i.ready;

  // Only the low SAMPLE_WIDTH bits of the sample carry the value, sign-extended.
  assign x      = $signed(in_i.sample[SW-1:0]);
  assign d1     = {x[SW-1], x} - {mean_q[SW-1], mean_q};
  assign d1_mag = d1[SW] ? (~d1 + 1'b1) : d1;
  assign quot   = work_q[SW-1:0];

  // The mean moves toward the sample by the truncated quotient.
  assign mean_next = neg_q ? ({mean_q[SW-1], mean_q} - {1'b0, quot})
                           : ({mean_q[SW-1], mean_q} + {1'b0, quot});

  assign prod_shift = prod_q >> FRAC_BITS;
  assign sum_ext    = {1'b0, sum_q}
                    + {{(rmv_pkg::SUM_W + 1 - 2*SW){1'b0}}, prod_shift};
  assign mean_wide  = rmv_pkg::OUT_W'(mean_q);

  always_comb begin
    iter_req.mode    = ((state_q == S_DIVQ) || (state_q == S_DIVV)) ? rmv_pkg::MODE_DIV
                                                                    : rmv_pkg::MODE_SQRT;
    iter_req.rem     = rem_q;
    iter_req.in_bits = (state_q == S_SQRT) ? work_q[rmv_pkg::SUM_W-1 -: 2]
                                           : {work_q[rmv_pkg::SUM_W-1], 1'b0};
    iter_req.divisor = count_q;
    iter_req.root    = root_q;
  end

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    mean_d      = mean_q;
    sum_d       = sum_q;
    ovf_d       = ovf_q;
    cnt_d       = cnt_q;
    work_d      = work_q;
    rem_d       = rem_q;
    root_d      = root_q;
    mag1_d      = mag1_q;
    mag2_d      = mag2_q;
    neg_d       = neg_q;
    prod_d      = prod_q;
    out_valid_d = out_valid_q;
    out_count_d = out_count_q;
    out_mean_d  = out_mean_q;
    out_sum_d   = out_sum_q;
    out_dev_d   = out_dev_q;
    out_ovf_d   = out_ovf_q;

    if (out_valid_q && res_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          if (in_i.func == rmv_pkg::FUNC_CLEAR) begin
            count_d = '0;
            mean_d  = '0;
            sum_d   = '0;
            ovf_d   = 1'b0;
            root_d  = '0;
            state_d = S_FINISH;
          end else begin
            // The count saturates instead of wrapping.
            if (count_q == '1) begin
              ovf_d = 1'b1;
            end else begin
              count_d = count_q + 1'b1;
            end
            if (count_q == '0) begin
              // First sample: the mean is the sample, the sum restarts at zero.
              mean_d  = x;
              sum_d   = '0;
              prod_d  = '0;
              state_d = S_SUM;
            end else begin
              neg_d   = d1[SW];
              mag1_d  = d1_mag[SW-1:0];
              work_d  = {d1_mag[SW-1:0], {(rmv_pkg::SUM_W - SW){1'b0}}};
              rem_d   = '0;
              cnt_d   = rmv_pkg::CNT_W'(SW - 1);
              state_d = S_DIVQ;
            end
          end
        end
      end
      S_DIVQ: begin
        work_d = {work_q[rmv_pkg::SUM_W-2:0], iter_rsp.bit_val};
        rem_d  = iter_rsp.rem;
        cnt_d  = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          state_d = S_MEAN;
        end
      end
      S_MEAN: begin
        mean_d  = mean_next[SW-1:0];
        mag2_d  = mag1_q - quot;
        state_d = S_MUL;
      end
      S_MUL: begin
        prod_d  = {{SW{1'b0}}, mag1_q} * {{SW{1'b0}}, mag2_q};
        state_d = S_SUM;
      end
      S_SUM: begin
        if (sum_ext[rmv_pkg::SUM_W]) begin
          sum_d  = '1;
          work_d = '1;
          ovf_d  = 1'b1;
        end else begin
          sum_d  = sum_ext[rmv_pkg::SUM_W-1:0];
          work_d = sum_ext[rmv_pkg::SUM_W-1:0];
        end
        rem_d   = '0;
        cnt_d   = rmv_pkg::CNT_W'(rmv_pkg::SUM_W - 1);
        state_d = S_DIVV;
      end
      S_DIVV: begin
        work_d = {work_q[rmv_pkg::SUM_W-2:0], iter_rsp.bit_val};
        rem_d  = iter_rsp.rem;
        cnt_d  = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          state_d = S_SQPREP;
        end
      end
      S_SQPREP: begin
        // The variance must still fit once scaled up by the fraction bits.
        if ((work_q >> SatShift) != '0) begin
          root_d  = '1;
          ovf_d   = 1'b1;
          state_d = S_FINISH;
        end else begin
          work_d  = work_q << FRAC_BITS;
          rem_d   = '0;
          root_d  = '0;
          cnt_d   = rmv_pkg::CNT_W'(rmv_pkg::DEV_W - 1);
          state_d = S_SQRT;
        end
      end
      S_SQRT: begin
        work_d = {work_q[rmv_pkg::SUM_W-3:0], 2'b00};
        rem_d  = iter_rsp.rem;
        root_d = {root_q[rmv_pkg::DEV_W-2:0], iter_rsp.bit_val};
        cnt_d  = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          state_d = S_FINISH;
        end
      end
      S_FINISH: begin
        if (!out_valid_q || res_o.ready) begin
          out_valid_d = 1'b1;
          out_count_d = count_q;
          out_mean_d  = mean_wide;
          out_sum_d   = sum_q;
          out_dev_d   = root_q;
          out_ovf_d   = ovf_q;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      mean_q      <= '0;
      sum_q       <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      mean_q      <= mean_d;
      sum_q       <= sum_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q       <= cnt_d;
    work_q      <= work_d;
    rem_q       <= rem_d;
    root_q      <= root_d;
    mag1_q      <= mag1_d;
    mag2_q      <= mag2_d;
    neg_q       <= neg_d;
    prod_q      <= prod_d;
    out_count_q <= out_count_d;
    out_mean_q  <= out_mean_d;
    out_sum_q   <= out_sum_d;
    out_dev_q   <= out_dev_d;
    out_ovf_q   <= out_ovf_d;
  end

  assign res_o.valid           = out_valid_q;
  assign res_o.sample_count    = out_count_q;
  assign res_o.mean_value      = out_mean_q;
  assign res_o.squared_dev_sum = out_sum_q;
  assign res_o.std_deviation   = out_dev_q;
  assign res_o.overflow        = out_ovf_q;

  // Once a word is taken the core is busy on it and not ready in the next cycle.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> !in_i.ready)
    else $error("core took a new word right after accepting one");

  // The overflow flag only drops on a clear word.
  a_overflow_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovf_q && !(in_fire && (in_i.func == rmv_pkg::FUNC_CLEAR)) |=> ovf_q)
    else $error("overflow flag dropped without a clear");

  // A saturating sum update leaves the sum at full scale and the flag set.
  a_sum_saturates: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SUM) && sum_ext[rmv_pkg::SUM_W] |=> ovf_q && (sum_q == '1))
    else $error("sum overflow not saturated");

  // A result with no samples behind it carries no spread and no overflow.
  a_empty_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && (res_o.sample_count == '0)
      |-> (res_o.std_deviation == '0) && (res_o.squared_dev_sum == '0) && !res_o.overflow)
    else $error("empty statistics reported nonzero spread");

endmodule

`default_nettype wire

>>> test/tb_top.sv
// Self-checking testbench of the running mean and variance core.
`timescale 1ns / 1ps

module tb_top;

  localparam int SAMPLE_W = 32;
  localparam int FRAC_W   = 16;
  // The slowest correct run is about 2000 words, each taking the longest add path, plus
  // both sides' longest idles. The limit below is several times that.
  localparam int unsigned CYCLE_LIMIT = 2_000_000;
  // Long enough to cover one add word, so that any stray result shows at the end.
  localparam int SETTLE_CYCLES = 150;

  // One result word, field by field.
  typedef struct packed {
    logic [rmv_pkg::COUNT_W-1:0] count;
    logic [rmv_pkg::OUT_W-1:0]   mean;
    logic [rmv_pkg::SUM_W-1:0]   dev_sum;
    logic [rmv_pkg::DEV_W-1:0]   std_dev;
    logic                        ovf;
  } stats_word_t;

  logic clk_i;
  logic rst_ni;

  rmv_in_if  in_if ();
  rmv_out_if res_if ();

  running_mean_variance_core #(
    .SAMPLE_WIDTH(SAMPLE_W),
    .FRAC_BITS   (FRAC_W)
  ) DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .res_o (res_if)
  );

  // Predicted statistics. The mean is kept at 64 bits so that the difference of a
  // sample and the mean never wraps.
  logic [rmv_pkg::COUNT_W-1:0] acc_count;
  longint                      acc_mean;
  logic [rmv_pkg::SUM_W-1:0]   acc_sum;
  logic                        acc_ovf;

  // Result words that have been predicted and not yet seen, oldest first.
  stats_word_t pending_stats_q[$];

  // Idling control. When idle_en is low both sides run back to back.
  logic        idle_en;
  int unsigned stall_left;
  logic        res_taken;

  // Bookkeeping for the final report.
  int unsigned cycle_cnt;
  int unsigned bad_words;
  int unsigned checked_words;
  int unsigned add_words;
  int unsigned clear_words;
  int unsigned idle_pauses;
  logic [rmv_pkg::COUNT_W-1:0] peak_count;

  // The clock starts low; the first rising edge comes at 4 ns.
  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  function automatic int unsigned draw_wait();
    return idle_en ? $urandom_range(0, 7) : 0;
  endfunction

  // Bit-serial integer square root, floor of sqrt(v).
  function automatic logic [63:0] int_sqrt(logic [63:0] v);
    logic [63:0] root;
    logic [63:0] probe;
    root  = '0;
    probe = 64'h1 << 62;
    while (probe > v) probe = probe >> 2;
    while (probe != 0) begin
      if (v >= root + probe) begin
        v    = v - (root + probe);
        root = (root >> 1) + probe;
      end else begin
        root = root >> 1;
      end
      probe = probe >> 2;
    end
    return root;
  endfunction

  // Applies one input word to the predicted statistics and returns the result word
  // the core must produce for it.
  function automatic stats_word_t welford_update(logic op, logic [31:0] raw);
    stats_word_t w;
    longint      x;
    longint      d_old;
    longint      d_new;
    logic [63:0] mag_old;
    logic [63:0] mag_new;
    logic [63:0] step;
    logic [63:0] prod;
    logic [64:0] wide_sum;
    logic [63:0] var_q;
    logic [63:0] dev;
    w   = '0;
    dev = '0;
    if (op == rmv_pkg::FUNC_CLEAR) begin
      acc_count = '0;
      acc_mean  = 0;
      acc_sum   = '0;
      acc_ovf   = 1'b0;
    end else begin
      x = longint'($signed(raw[SAMPLE_W-1:0]));
      // The count sticks at its maximum; further samples then set the flag and still update the mean and sum.
      if (acc_count == '1) acc_ovf = 1'b1;
      else acc_count = acc_count + 1'b1;

      if (acc_count == 1) begin
        // The first sample after a clear loads the mean and leaves no spread.
        acc_mean = x;
        acc_sum  = '0;
      end else begin
        d_old   = x - acc_mean;
        mag_old = (d_old < 0) ? -d_old : d_old;
        // The mean moves by the truncated quotient, toward the sample.
        step     = mag_old / {32'd0, acc_count};
        acc_mean = (d_old < 0) ? acc_mean - longint'(step) : acc_mean + longint'(step);
        d_new    = x - acc_mean;
        mag_new  = (d_new < 0) ? -d_new : d_new;
        // Both magnitudes are below 2^32, so the product fits in 64 bits.
        prod     = (mag_old * mag_new) >> FRAC_W;
        wide_sum = {1'b0, acc_sum} + {1'b0, prod};
        if (wide_sum[64]) begin
          acc_sum = '1;
          acc_ovf = 1'b1;
        end else begin
          acc_sum = wide_sum[63:0];
        end
      end

      var_q = acc_sum / {32'd0, acc_count};
      if ((var_q >> (64 - FRAC_W)) != 0) begin
        // Shifting the variance up would lose bits: the root cannot fit.
        dev     = 64'hFFFF_FFFF;
        acc_ovf = 1'b1;
      end else begin
        dev = int_sqrt(var_q << FRAC_W);
        if (dev > 64'hFFFF_FFFF) begin
          dev     = 64'hFFFF_FFFF;
          acc_ovf = 1'b1;
        end
      end
    end
    if (acc_count > peak_count) peak_count = acc_count;
    w.count   = acc_count;
    w.mean    = acc_mean[rmv_pkg::OUT_W-1:0];
    w.dev_sum = acc_sum;
    w.std_dev = dev[rmv_pkg::DEV_W-1:0];
    w.ovf     = acc_ovf;
    return w;
  endfunction

  // Sends one input word. The payload changes at the falling edge; the word counts
  // as accepted at the first rising edge that sees valid and ready high together.
  // Valid stays high on return, so a following word with no gap goes out at once.
  task automatic send_word(input logic op, input logic [31:0] raw);
    int unsigned gap;
    logic        after_ready;
    gap         = draw_wait();
    after_ready = idle_en && ($urandom_range(0, 1) == 1);
    @(negedge clk_i);
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      // Half of the gaps start only once the core asks for the next word, so that
      // they also fall right at the start of a computation and not only in its middle.
      if (after_ready) begin
        while (!in_if.ready) @(negedge clk_i);
      end
      repeat (gap) @(negedge clk_i);
    end
    in_if.valid  <= 1'b1;
    in_if.func   <= op;
    in_if.sample <= raw;
    do begin
      @(posedge clk_i);
    end while (!(in_if.valid && in_if.ready));
    pending_stats_q.push_back(welford_update(op, raw));
    if (op == rmv_pkg::FUNC_CLEAR) clear_words++;
    else add_words++;
  endtask

  // Stops sending and waits until every predicted result has been taken.
  task automatic wait_all_results();
    @(negedge clk_i);
    in_if.valid <= 1'b0;
    while (pending_stats_q.size() != 0) @(posedge clk_i);
    idle_pauses++;
  endtask

  // Samples for random runs: mostly clustered around a base value so that the
  // spread stays in a useful range, mixed with full range, small and extreme values.
  function automatic logic [31:0] draw_sample(logic [31:0] base);
    logic [31:0] val;
    logic [31:0] offset;
    int unsigned span;
    case ($urandom_range(0, 9))
      0, 1, 2: val = $urandom;
      3: begin
        case ($urandom_range(0, 4))
          0:       val = 32'h7FFF_FFFF;
          1:       val = 32'h8000_0000;
          2:       val = 32'h0000_0000;
          3:       val = 32'hFFFF_FFFF;
          default: val = 32'h0000_0001;
        endcase
      end
      4: val = 32'($urandom_range(0, 511)) - 32'd256;
      default: begin
        span   = $urandom_range(0, 24);
        offset = $urandom & ((32'h1 << span) - 32'h1);
        val    = ($urandom_range(0, 1) == 1) ? base + offset : base - offset;
      end
    endcase
    return val;
  endfunction

  // Compares one result word with the oldest prediction.
  task automatic check_stats(input stats_word_t got);
    stats_word_t want;
    string       bad_fields;
    if (pending_stats_q.size() == 0) begin
      bad_words++;
      if (bad_words <= 10)
        $display("unexpected result word: count=%0d mean=%h sum=%h dev=%h ovf=%b",
                 got.count, got.mean, got.dev_sum, got.std_dev, got.ovf);
    end else begin
      want       = pending_stats_q.pop_front();
      bad_fields = "";
      checked_words++;
      if (got.count !== want.count) bad_fields = {bad_fields, " sample_count"};
      if (got.mean !== want.mean) bad_fields = {bad_fields, " mean_value"};
      if (got.dev_sum !== want.dev_sum) bad_fields = {bad_fields, " squared_dev_sum"};
      if (got.std_dev !== want.std_dev) bad_fields = {bad_fields, " std_deviation"};
      if (got.ovf !== want.ovf) bad_fields = {bad_fields, " overflow"};
      if (bad_fields != "") begin
        bad_words++;
        if (bad_words <= 10) begin
          $display("mismatch on result %0d in%s: expected count=%0d mean=%h sum=%h dev=%h ovf=%b",
                   checked_words, bad_fields, want.count, want.mean, want.dev_sum,
                   want.std_dev, want.ovf);
          $display("  got count=%0d mean=%h sum=%h dev=%h ovf=%b",
                   got.count, got.mean, got.dev_sum, got.std_dev, got.ovf);
        end
      end
    end
  endtask

  // Result side: outputs are sampled at the rising edge. The cycle counter here
  // also ends a run that hangs.
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles with %0d results outstanding", cycle_cnt,
               pending_stats_q.size());
      $display("tb_top NOT OK");
      $finish;
    end else if (rst_ni && res_if.valid && res_if.ready) begin
      res_taken = 1'b1;
      check_stats({res_if.sample_count, res_if.mean_value, res_if.squared_dev_sum,
                   res_if.std_deviation, res_if.overflow});
    end
  end

  // Result side: ready changes at the falling edge. After each taken word a new stall
  // is drawn; ready is driven once per edge, so it never glitches within a step.
  always @(negedge clk_i) begin
    if (res_taken) begin
      res_taken  = 1'b0;
      stall_left = draw_wait();
    end
    if (stall_left != 0) begin
      res_if.ready <= 1'b0;
      stall_left--;
    end else begin
      res_if.ready <= 1'b1;
    end
  end

  // A clear on fresh state, a clear whose sample field is all ones, a sample, and
  // a clear that drops a single accumulated sample.
  task automatic test_clear_cases();
    send_word(rmv_pkg::FUNC_CLEAR, 32'h0000_0000);
    send_word(rmv_pkg::FUNC_CLEAR, 32'hFFFF_FFFF);
    send_word(rmv_pkg::FUNC_ADD, 32'h0005_0000);
    send_word(rmv_pkg::FUNC_CLEAR, 32'h1234_5678);
  endtask

  // Extreme samples. The first loads the mean directly; the jump from the largest
  // to the smallest value gives the widest difference and product the core can see.
  task automatic test_field_extremes();
    send_word(rmv_pkg::FUNC_ADD, 32'h7FFF_FFFF);
    send_word(rmv_pkg::FUNC_ADD, 32'h8000_0000);
    send_word(rmv_pkg::FUNC_ADD, 32'h0000_0000);
    send_word(rmv_pkg::FUNC_ADD, 32'hFFFF_FFFF);
    send_word(rmv_pkg::FUNC_ADD, 32'h0000_0001);
    send_word(rmv_pkg::FUNC_ADD, 32'h8000_0000);
    send_word(rmv_pkg::FUNC_ADD, 32'h7FFF_FFFF);
  endtask

  // Equal samples keep the spread at zero. Then two small steps below the mean whose
  // quotient by the count truncates toward zero, and one above it that divides exactly.
  task automatic test_constant_and_truncation();
    send_word(rmv_pkg::FUNC_CLEAR, 32'h0000_0000);
    repeat (3) send_word(rmv_pkg::FUNC_ADD, 32'h0001_8000);
    send_word(rmv_pkg::FUNC_CLEAR, 32'h0000_0000);
    send_word(rmv_pkg::FUNC_ADD, 32'd10);
    send_word(rmv_pkg::FUNC_ADD, 32'd3);
    send_word(rmv_pkg::FUNC_ADD, 32'hFFFF_FFFC);
    send_word(rmv_pkg::FUNC_ADD, 32'd40);
  endtask

  // Random runs: most start with a clear and add up to 60 samples around a random
  // base; some carry on from the previous run. Every few hundred words the sender
  // holds off until the core has delivered everything.
  task automatic test_random_runs(input int unsigned n_words);
    int unsigned sent;
    int unsigned run_len;
    int unsigned next_pause;
    logic [31:0] base;
    sent       = 0;
    next_pause = 350;
    while (sent < n_words) begin
      if ($urandom_range(0, 9) != 0) begin
        send_word(rmv_pkg::FUNC_CLEAR, $urandom);
        sent++;
      end
      run_len = $urandom_range(1, 60);
      base    = $urandom;
      repeat (run_len) begin
        send_word(rmv_pkg::FUNC_ADD, draw_sample(base));
        sent++;
      end
      if (sent >= next_pause) begin
        wait_all_results();
        next_pause += 350;
      end
    end
  endtask

  // The same random runs with neither side idling.
  task automatic test_back_to_back(input int unsigned n_words);
    idle_en = 1'b0;
    test_random_runs(n_words);
    idle_en = 1'b1;
  endtask

  // One long run without a clear, so the count grows large and the sum carries
  // the spread of full range and extreme samples.
  task automatic test_long_accumulation(input int unsigned n_words);
    send_word(rmv_pkg::FUNC_CLEAR, 32'h0000_0000);
    repeat (n_words) begin
      if ($urandom_range(0, 3) == 0)
        send_word(rmv_pkg::FUNC_ADD,
                  ($urandom_range(0, 1) == 1) ? 32'h7FFF_FFFF : 32'h8000_0000);
      else
        send_word(rmv_pkg::FUNC_ADD, $urandom);
    end
  endtask

  initial begin
    rst_ni        = 1'b0;
    in_if.valid   = 1'b0;
    in_if.func    = rmv_pkg::FUNC_ADD;
    in_if.sample  = '0;
    res_if.ready  = 1'b0;
    idle_en       = 1'b1;
    stall_left    = 0;
    res_taken     = 1'b0;
    cycle_cnt     = 0;
    bad_words     = 0;
    checked_words = 0;
    add_words     = 0;
    clear_words   = 0;
    idle_pauses   = 0;
    peak_count    = '0;
    acc_count     = '0;
    acc_mean      = 0;
    acc_sum       = '0;
    acc_ovf       = 1'b0;

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_clear_cases();
    test_field_extremes();
    test_constant_and_truncation();
    test_random_runs(1400);
    test_back_to_back(300);
    test_long_accumulation(230);

    // Drain, then give the core time to show any word it should not send.
    wait_all_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (pending_stats_q.size() != 0) begin
      bad_words += pending_stats_q.size();
      $display("%0d predicted results never arrived", pending_stats_q.size());
    end

    $display("sent %0d add and %0d clear words, checked %0d results, %0d errors",
             add_words, clear_words, checked_words, bad_words);
    $display("longest accumulation reached %0d samples; sender held off %0d times",
             peak_count, idle_pauses);
    if (bad_words == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
